// File: rtl/hkt_pkg.sv
// hkt_pkg: types, widths, latencies and fixed-point constants of the knee tone mapper.
// Holds the root table builder used by the exp2 pipeline. No dependencies.
package hkt_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int LQ         = 24;
	localparam int LOG_FB     = 16 + FRAC_BITS;
	localparam int GAIN_BIAS  = 41505658;
	localparam int LN2_Q30    = 744261118;
	localparam int OUT_ANCHOR = 58720256;

	localparam int VAL_W      = 32;
	localparam int RAD_W      = VAL_W + 16;
	localparam int LOG_IN_W   = 64;
	localparam int LIN_W      = 61;
	localparam int LOG_W      = 34;
	localparam int EXP_W      = 40;
	localparam int DIV_NUM_W  = 46;
	localparam int DIV_DEN_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	localparam int LOG_LAT    = LQ + 1;
	localparam int EXP_LAT    = LQ + 1;
	localparam int DIV_LAT    = DIV_NUM_W;
	localparam int PIPE_DEPTH = 1 + LOG_LAT + 1 + EXP_LAT + 1 + 1 + LOG_LAT + 1 + DIV_LAT
		+ 1 + LOG_LAT + 1 + 1 + 1 + EXP_LAT + 1;

	typedef struct packed {
		logic [VAL_W-1:0] red_value;
		logic [VAL_W-1:0] green_value;
		logic [VAL_W-1:0] blue_value;
	} rad_word_t;

	typedef struct packed {
		logic [7:0] red_byte;
		logic [7:0] green_byte;
		logic [7:0] blue_byte;
	} disp_word_t;

	typedef struct packed {
		logic [21:0] exposure;
		logic [15:0] defog;
		logic [20:0] knee_low;
		logic [15:0] knee_factor;
		logic [17:0] gamma_exponent;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXPOSURE,
		CFG_DEFOG,
		CFG_KNEE_LOW,
		CFG_KNEE_FACTOR,
		CFG_GAMMA
	} cfg_reg_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] a);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		x = a;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q30 value of 2^(2^-i), built by repeated square roots
	function automatic logic [30:0] exp2_root(input int i);
		logic [63:0] c;
		c = 64'h8000_0000;
		for (int k = 1; k <= i; k++)
			c = isqrt64(c << 30);
		return c[30:0];
	endfunction

endpackage

// File: rtl/hdr_knee_tone_mapper_unit.sv
// Channel   Handshake          Word
// rad       rad_valid/stall    rad_word_t, three Q16.16 radiances
// disp      disp_valid/stall   disp_word_t, three display bytes
// cfg       cfg_valid/ready    cfg_index, cfg_data
// One pixel enters per clock unless the output stalls; the pipeline length is set by the
// chain of three log units, two exp units and the one-bit-per-stage divider.
// The whole pipeline advances as one; a stalled output word freezes it and
// stalls the input. Reset clears valid bits and loads register defaults.
// Depends on hkt_pkg, hkt_exp2, hkt_chan.
module hdr_knee_tone_mapper_unit import hkt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rad_valid,
	output logic                  rad_stall,
	input  rad_word_t             rad,
	output logic                  disp_valid,
	input  logic                  disp_stall,
	output disp_word_t            disp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_s;
	logic [LIN_W-1:0]      kl_lin;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exposure       <= '0;
			cfg_q.defog          <= '0;
			cfg_q.knee_low       <= '0;
			cfg_q.knee_factor    <= 16'd12426;
			cfg_q.gamma_exponent <= 18'd29789;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EXPOSURE:    cfg_q.exposure       <= cfg_data;
				CFG_DEFOG:       cfg_q.defog          <= cfg_data[15:0];
				CFG_KNEE_LOW:    cfg_q.knee_low       <= cfg_data[20:0];
				CFG_KNEE_FACTOR: cfg_q.knee_factor    <= cfg_data[15:0];
				CFG_GAMMA:       cfg_q.gamma_exponent <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	assign en         = !(vld_s[PIPE_DEPTH-1] && disp_stall);
	assign rad_stall  = !en;
	assign disp_valid = vld_s[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[PIPE_DEPTH-2:0], rad_valid};
	end

	// knee threshold in linear form, shared by all channels
	hkt_exp2 u_kl_exp (
		.clk(clk), .en(1'b1),
		.l(EXP_W'($signed({cfg_q.knee_low, 8'b0}))),
		.lin(kl_lin)
	);

	hkt_chan u_red (.clk(clk), .en(en), .cfg(cfg_q), .kl_lin(kl_lin),
		.raw(rad.red_value), .tone(disp.red_byte));
	hkt_chan u_green (.clk(clk), .en(en), .cfg(cfg_q), .kl_lin(kl_lin),
		.raw(rad.green_value), .tone(disp.green_byte));
	hkt_chan u_blue (.clk(clk), .en(en), .cfg(cfg_q), .kl_lin(kl_lin),
		.raw(rad.blue_value), .tone(disp.blue_byte));

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rad_stall |-> disp_valid)
		else $error("input stalled with no word waiting at output");

	a_valid_advances: assert property (@(posedge clk) disable iff (!arst_n)
		!disp_stall |=> disp_valid == $past(vld_s[PIPE_DEPTH-2]))
		else $error("output valid did not follow pipeline");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		rad_valid && !rad_stall |=> vld_s[0])
		else $error("accepted word missing from first stage");
`endif

endmodule

// File: rtl/hkt_log2.sv
// hkt_log2: pipelined base-2 log, one squaring per stage, Q24 fraction out.
// Depends on hkt_pkg.
module hkt_log2 import hkt_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [LOG_IN_W-1:0] v,
	output logic [5:0]          p,
	output logic [LQ-1:0]       fr
);

	logic [5:0]          p_c;
	logic [LOG_IN_W-1:0] sh_c;
	logic [30:0]         m_s  [LQ+1];
	logic [5:0]          p_s  [LQ+1];
	logic [LQ-1:0]       fr_s [LQ+1];

	// top set bit, then normalize to Q30 in [1,2)
	always_comb begin
		p_c = '0;
		for (int i = 0; i < LOG_IN_W; i++)
			if (v[i])
				p_c = 6'(i);
		if (p_c >= 6'd30)
			sh_c = v >> (p_c - 6'd30);
		else
			sh_c = v << (6'd30 - p_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= sh_c[30:0];
			p_s[0]  <= p_c;
			fr_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= LQ; k++) begin : g_sq
		logic [61:0] sq;
		assign sq = m_s[k-1] * m_s[k-1];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k]  <= sq[61] ? sq[61:31] : sq[60:30];
				fr_s[k] <= fr_s[k-1] | (LQ'(sq[61]) << (LQ - k));
				p_s[k]  <= p_s[k-1];
			end
		end
	end

	assign p  = p_s[LQ];
	assign fr = fr_s[LQ];

endmodule

// File: rtl/hkt_exp2.sv
// hkt_exp2: pipelined exp2 of a signed Q24 log, one root product per stage,
// linear Q24 out saturated at 2^60. Depends on hkt_pkg.
module hkt_exp2 import hkt_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [EXP_W-1:0] l,
	output logic [LIN_W-1:0]        lin
);

	localparam int NW = EXP_W - LQ;
	localparam logic [30:0] ROOT1 = exp2_root(1);
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic signed [NW-1:0] N_SAT = 36;
	localparam logic signed [NW-1:0] N_UNIT = 6;

	logic [30:0]             r_s [LQ];
	logic signed [NW-1:0]    n_s [LQ];
	logic [LQ-1:0]           f_s [LQ];
	logic signed [NW-1:0]    nf;
	logic [30:0]             rf;
	logic [NW-1:0]           rs;
	logic [LIN_W-1:0]        lin_c;
	logic [LIN_W-1:0]        lin_s25;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= l[LQ-1] ? ROOT1 : ONE_Q30;
			n_s[0] <= l[EXP_W-1:LQ];
			f_s[0] <= l[LQ-1:0];
		end
	end

	for (genvar k = 1; k < LQ; k++) begin : g_mul
		localparam logic [30:0] ROOT = exp2_root(k + 1);
		logic [61:0] prod;
		assign prod = r_s[k-1] * ROOT;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= f_s[k-1][LQ-1-k] ? prod[60:30] : r_s[k-1];
				n_s[k] <= n_s[k-1];
				f_s[k] <= f_s[k-1];
			end
		end
	end

	assign nf = n_s[LQ-1];
	assign rf = r_s[LQ-1];
	assign rs = NW'(N_UNIT - nf);

	// scale mantissa by 2^(n-6) into Q24
	always_comb begin
		if (nf >= N_SAT)
			lin_c = LIN_W'(1) << 60;
		else if (nf >= N_UNIT)
			lin_c = LIN_W'(rf) << 5'(nf - N_UNIT);
		else if (rs >= NW'(31))
			lin_c = '0;
		else
			lin_c = LIN_W'(rf >> 5'(rs));
	end

	always_ff @(posedge clk) begin
		if (en)
			lin_s25 <= lin_c;
	end

	assign lin = lin_s25;

endmodule

// File: rtl/hkt_div.sv
// hkt_div: restoring divider, one quotient bit per pipeline stage.
// Depends on hkt_pkg.
module hkt_div import hkt_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] q
);

	logic [DIV_DEN_W-1:0] rem_s [DIV_LAT];
	logic [DIV_NUM_W-1:0] w_s   [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
		logic [DIV_DEN_W-1:0] rem_p;
		logic [DIV_NUM_W-1:0] w_p;
		logic [DIV_DEN_W:0]   t;
		logic [DIV_DEN_W:0]   diff;
		logic                 ge;
		if (k == 0) begin : g_first
			assign rem_p = '0;
			assign w_p   = num;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign w_p   = w_s[k-1];
		end
		assign t    = {rem_p, w_p[DIV_NUM_W-1]};
		assign ge   = t >= {1'b0, den};
		assign diff = t - {1'b0, den};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DIV_DEN_W-1:0] : t[DIV_DEN_W-1:0];
				w_s[k]   <= {w_p[DIV_NUM_W-2:0], ge};
			end
		end
	end

	assign q = w_s[DIV_LAT-1];

endmodule

// File: rtl/hkt_chan.sv
// hkt_chan: one color channel: defog, log gain, knee, gamma, byte out.
// Depends on hkt_pkg, hkt_log2, hkt_exp2, hkt_div.
module hkt_chan import hkt_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  cfg_t              cfg,
	input  logic [LIN_W-1:0]  kl_lin,
	input  logic [VAL_W-1:0]  raw,
	output logic [7:0]        tone
);

	localparam int D_LO = LOG_LAT + 1 + EXP_LAT + 1 + 1 + LOG_LAT + 1 + DIV_LAT + 1 + LOG_LAT;
	localparam int D_L  = EXP_LAT + 1 + 1 + LOG_LAT + 1 + DIV_LAT + 1 + LOG_LAT;
	localparam int D_D  = 1 + LOG_LAT + 1 + DIV_LAT;
	localparam int D_XZ = LOG_LAT;
	localparam int D_T  = EXP_LAT;
	localparam logic signed [LOG_W:0] ANCHOR = OUT_ANCHOR;

	// defog
	logic [RAD_W-1:0] a_in;
	logic [RAD_W-1:0] b_in;
	logic [RAD_W-1:0] v_s1;
	logic             lo_s1;

	assign a_in = {raw, 16'b0};
	assign b_in = RAD_W'(cfg.defog) << FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1  <= a_in - b_in;
			lo_s1 <= a_in <= b_in;
		end
	end

	// log of radiance plus gain
	logic [5:0]            pa;
	logic [LQ-1:0]         fa;
	logic signed [7:0]     pe_a;
	logic signed [LOG_W-1:0] l_c;
	logic signed [LOG_W-1:0] kl_log;
	logic signed [LOG_W-1:0] l_s2;
	logic                  knee_s2;

	hkt_log2 u_log_a (.clk(clk), .en(en), .v(LOG_IN_W'(v_s1)), .p(pa), .fr(fa));

	assign pe_a   = $signed(8'({2'b00, pa}) - 8'(LOG_FB));
	assign l_c    = LOG_W'($signed({pe_a, fa})) + LOG_W'($signed({cfg.exposure, 8'b0}))
		+ LOG_W'(GAIN_BIAS);
	assign kl_log = LOG_W'($signed({cfg.knee_low, 8'b0}));

	always_ff @(posedge clk) begin
		if (en) begin
			l_s2    <= l_c;
			knee_s2 <= l_c > kl_log;
		end
	end

	// knee: distance above threshold in linear Q24
	logic [LIN_W-1:0] xl;
	logic [LIN_W-1:0] d_s3;
	logic [44:0]      zh;
	logic [47:0]      zl;
	logic [LIN_W-1:0] z_s4;

	hkt_exp2 u_exp_a (.clk(clk), .en(en), .l(EXP_W'(l_s2)), .lin(xl));

	assign zh = d_s3[LIN_W-1:32] * cfg.knee_factor;
	assign zl = d_s3[31:0] * cfg.knee_factor;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= (xl > kl_lin) ? xl - kl_lin : '0;
			z_s4 <= LIN_W'({zh, 16'b0}) + LIN_W'(zl[47:16]);
		end
	end

	// ln(1 + z) then divide by f
	logic [5:0]       pb;
	logic [LQ-1:0]    fb;
	logic [29:0]      lw;
	logic [59:0]      lnp;
	logic [29:0]      ln_s5;
	logic [DIV_NUM_W-1:0] qk;

	hkt_log2 u_log_b (.clk(clk), .en(en), .v(LOG_IN_W'(z_s4) + (LOG_IN_W'(1) << LQ)),
		.p(pb), .fr(fb));

	assign lw  = {6'(pb - 6'd24), fb};
	assign lnp = lw * 30'(LN2_Q30);

	always_ff @(posedge clk) begin
		if (en)
			ln_s5 <= lnp[59:30];
	end

	hkt_div u_div (.clk(clk), .en(en), .num({ln_s5, 16'b0}), .den(cfg.knee_factor), .q(qk));

	// hold d until the quotient arrives
	logic [LIN_W-1:0] d_line_s [D_D];

	always_ff @(posedge clk) begin
		if (en) begin
			d_line_s[0] <= d_s3;
			for (int i = 1; i < D_D; i++)
				d_line_s[i] <= d_line_s[i-1];
		end
	end

	logic [LIN_W-1:0] kk;
	logic [LIN_W:0]   xt_s6;
	logic             xtz_s6;
	logic [LIN_W:0]   xt_c;

	assign kk   = (cfg.knee_factor == '0) ? d_line_s[D_D-1] : LIN_W'(qk);
	assign xt_c = {1'b0, kl_lin} + {1'b0, kk};

	always_ff @(posedge clk) begin
		if (en) begin
			xt_s6  <= xt_c;
			xtz_s6 <= xt_c == '0;
		end
	end

	// back to log domain
	logic [5:0]        pc;
	logic [LQ-1:0]     fc;
	logic signed [7:0] pe_c;
	logic signed [LOG_W-1:0] yk;

	hkt_log2 u_log_c (.clk(clk), .en(en), .v(LOG_IN_W'(xt_s6)), .p(pc), .fr(fc));

	assign pe_c = $signed(8'({2'b00, pc}) - 8'(LQ));
	assign yk   = LOG_W'($signed({pe_c, fc}));

	logic            lo_line_s  [D_LO];
	logic [LOG_W:0]  l_line_s   [D_L];
	logic            xtz_line_s [D_XZ];

	always_ff @(posedge clk) begin
		if (en) begin
			lo_line_s[0]  <= lo_s1;
			l_line_s[0]   <= {knee_s2, l_s2};
			xtz_line_s[0] <= xtz_s6;
			for (int i = 1; i < D_LO; i++)
				lo_line_s[i] <= lo_line_s[i-1];
			for (int i = 1; i < D_L; i++)
				l_line_s[i] <= l_line_s[i-1];
			for (int i = 1; i < D_XZ; i++)
				xtz_line_s[i] <= xtz_line_s[i-1];
		end
	end

	logic                  knee_d;
	logic signed [LOG_W-1:0] l_d;
	logic signed [LOG_W-1:0] y_s7;
	logic                  spec_s7;

	assign knee_d = l_line_s[D_L-1][LOG_W];
	assign l_d    = $signed(l_line_s[D_L-1][LOG_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			y_s7    <= knee_d ? yk : l_d;
			spec_s7 <= lo_line_s[D_LO-1] | (knee_d & xtz_line_s[D_XZ-1]);
		end
	end

	// gamma exponent
	logic signed [LOG_W:0] yd;
	logic signed [53:0]    prod_s8;
	logic                  spec_s8;
	logic signed [EXP_W-1:0] e_s9;
	logic                  pos_s9;
	logic                  spec_s9;

	assign yd = (LOG_W+1)'(y_s7) - ANCHOR;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s8 <= yd * $signed({1'b0, cfg.gamma_exponent});
			spec_s8 <= spec_s7;
			e_s9    <= EXP_W'(prod_s8 >>> 16);
			pos_s9  <= !prod_s8[53];
			spec_s9 <= spec_s8;
		end
	end

	logic [LIN_W-1:0] xe;
	logic [1:0]       t_line_s [D_T];
	logic [31:0]      op;
	logic [7:0]       tone_s10;

	hkt_exp2 u_exp_b (.clk(clk), .en(en), .l(e_s9), .lin(xe));

	always_ff @(posedge clk) begin
		if (en) begin
			t_line_s[0] <= {spec_s9, pos_s9};
			for (int i = 1; i < D_T; i++)
				t_line_s[i] <= t_line_s[i-1];
		end
	end

	assign op = xe[LQ-1:0] * 9'd255;

	always_ff @(posedge clk) begin
		if (en) begin
			if (t_line_s[D_T-1][1])
				tone_s10 <= (cfg.gamma_exponent == '0) ? 8'hFF : 8'h00;
			else if (t_line_s[D_T-1][0])
				tone_s10 <= 8'hFF;
			else
				tone_s10 <= op[31:24];
		end
	end

	assign tone = tone_s10;

endmodule

// File: verif/hkt_tone_checker.sv
// Checker for the knee tone mapper: predicts display bytes from accepted radiance
// words and compares them with the output channel. Depends on hkt_pkg.
module hkt_tone_checker import hkt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rad_valid,
	input  logic                  rad_stall,
	input  rad_word_t             rad,
	input  logic                  disp_valid,
	input  logic                  disp_stall,
	input  disp_word_t            disp,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	logic [21:0] m_exposure;
	logic [15:0] m_defog;
	logic [20:0] m_knee_low;
	logic [15:0] m_knee_factor;
	logic [17:0] m_gamma;
	disp_word_t  expected_pixels[$];

	assign pending = expected_pixels.size();

	function automatic logic [63:0] sq_root(input logic [63:0] a);
		logic [63:0] r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > a)
			b = b >> 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a = a - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint log2_q24(input logic [63:0] v, input int fb);
		int p;
		logic [63:0] m, fr;
		p = 63;
		fr = 0;
		if (v == 0)
			return 0;
		while (p > 0 && !v[p])
			p--;
		m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
		for (int i = 1; i <= LQ; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				fr[LQ-i] = 1'b1;
			end
		end
		return longint'(p - fb) * (longint'(1) << LQ) + longint'(fr);
	endfunction

	function automatic logic [63:0] pow2_q24(input longint l);
		longint n, s;
		logic [63:0] mant, c, fr;
		n = l >>> LQ;
		fr = l - (n << LQ);
		mant = 64'd1 << 30;
		c = 64'd2 << 30;
		for (int i = 1; i <= LQ; i++) begin
			c = sq_root(c << 30);
			if (fr[LQ-i])
				mant = (mant * c) >> 30;
		end
		s = n - 6;
		if (n >= 36)
			return 64'd1 << 60;
		if (s >= 0)
			return mant << s;
		if (-s >= 63)
			return 0;
		return mant >> (-s);
	endfunction

	function automatic logic [7:0] tone_byte(input logic [31:0] raw);
		logic [63:0] a, b, f, xl, kl, d, z, lw, ln, k, xt, o;
		longint g, l, kl_log, y, e;
		a = {16'd0, raw, 16'd0};
		b = 64'(m_defog) << FRAC_BITS;
		f = 64'(m_knee_factor);
		g = longint'(m_gamma);
		if (a <= b)
			return (g == 0) ? 8'd255 : 8'd0;
		l = log2_q24(a - b, 16 + FRAC_BITS) + longint'($signed(m_exposure)) * 256
			+ GAIN_BIAS;
		kl_log = longint'($signed(m_knee_low)) * 256;
		if (l <= kl_log) begin
			y = l;
		end else begin
			xl = pow2_q24(l);
			kl = pow2_q24(kl_log);
			d = (xl > kl) ? xl - kl : 0;
			if (f == 0) begin
				k = d;
			end else begin
				z = (((d >> 32) * f) << 16) + (((d & 64'hFFFF_FFFF) * f) >> 16);
				lw = log2_q24(z + (64'd1 << LQ), LQ);
				ln = (lw * 64'(LN2_Q30)) >> 30;
				k = (ln << 16) / f;
			end
			xt = kl + k;
			if (xt == 0)
				return (g == 0) ? 8'd255 : 8'd0;
			y = log2_q24(xt, LQ);
		end
		e = ((y - OUT_ANCHOR) * g) >>> 16;
		if (e >= 0)
			return 8'd255;
		o = (pow2_q24(e) * 255) >> LQ;
		return (o > 255) ? 8'd255 : o[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		disp_word_t want;
		if (!arst_n) begin
			m_exposure <= '0;
			m_defog <= '0;
			m_knee_low <= '0;
			m_knee_factor <= 16'd12426;
			m_gamma <= 18'd29789;
			fail_count <= 0;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_EXPOSURE:    m_exposure <= cfg_data[21:0];
					CFG_DEFOG:       m_defog <= cfg_data[15:0];
					CFG_KNEE_LOW:    m_knee_low <= cfg_data[20:0];
					CFG_KNEE_FACTOR: m_knee_factor <= cfg_data[15:0];
					CFG_GAMMA:       m_gamma <= cfg_data[17:0];
					default: ;
				endcase
			end
			if (disp_valid && !disp_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected word %h", $time, disp);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (want !== disp) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, disp);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (rad_valid && !rad_stall) begin
				want.red_byte = tone_byte(rad.red_value);
				want.green_byte = tone_byte(rad.green_value);
				want.blue_byte = tone_byte(rad.blue_value);
				expected_pixels.push_back(want);
			end
		end
	end

endmodule

// File: verif/tb_hdr_knee_tone_mapper_unit.sv
// Testbench top for hdr_knee_tone_mapper_unit: drives radiance words and register
// writes, idles both channels; hkt_tone_checker does the comparing. Depends on hkt_pkg.
module tb_hdr_knee_tone_mapper_unit import hkt_pkg::*; ;

	localparam int CYCLE_LIMIT = 1200000;

	logic clk, arst_n;
	logic rad_valid, rad_stall, disp_valid, disp_stall;
	rad_word_t rad;
	disp_word_t disp;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count, pending, cycles;
	int send_idle_pct, recv_idle_pct;

	hdr_knee_tone_mapper_unit DUT (.*);
	hkt_tone_checker chk (.*);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		disp_stall <= ($urandom_range(99) < recv_idle_pct);
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_radiance();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(65535);
			2: return $urandom() >> $urandom_range(31);
			3: return {12'd0, 4'($urandom_range(15)), 16'($urandom())};
			default: return $urandom() >> $urandom_range(8, 24);
		endcase
	endfunction

	// valid stays high after the word is taken; drop it before any pause
	task automatic send_pixel(input logic [31:0] r, g, b);
		while ($urandom_range(99) < send_idle_pct) begin
			rad_valid <= 1'b0;
			@(posedge clk);
		end
		rad_valid <= 1'b1;
		rad <= '{r, g, b};
		@(posedge clk);
		while (rad_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		rad_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input int e, input int d, input int kl, input int kf,
			input int gm);
		write_reg(CFG_EXPOSURE, CFG_DATA_W'(e));
		write_reg(CFG_DEFOG, CFG_DATA_W'(d));
		write_reg(CFG_KNEE_LOW, CFG_DATA_W'(kl));
		write_reg(CFG_KNEE_FACTOR, CFG_DATA_W'(kf));
		write_reg(CFG_GAMMA, CFG_DATA_W'(gm));
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		rad_valid = 1'b0;
		rad = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 12;
		recv_idle_pct = 84;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes with reset defaults
		send_pixel(0, 0, 0);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(1, 32'h0001_0000, 32'h8000_0000);
		send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
		drain();
		// at or below fog, gamma zero, knee factor zero
		load_regs(0, 65535, 0, 0, 0);
		send_pixel(32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
		send_pixel(0, 32'h0000_8000, 32'h0010_0000);
		drain();
		load_regs(1048576, 0, 524288, 0, 262143);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 32'h0100_0000);
		send_pixel(32'h0001_0000, 32'h0000_1000, 32'h7FFF_FFFF);
		drain();
		load_regs(-1048576, 1, -524288, 1, 1);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 32'h0100_0000);
		send_pixel(32'h0001_0000, 32'h0000_1000, 32'h7FFF_FFFF);
		drain();
		load_regs(4194303, 32768, 2097151, 65535, 131072);
		send_pixel(32'hFFFF_FFFF, 32'h0000_8001, 32'h0003_0000);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 84;
				recv_idle_pct = 12;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_regs($urandom_range(2097152) - 1048576, $urandom_range(65535),
				$urandom_range(1048576) - 524288, $urandom_range(1, 65535),
				(phase == 5) ? 29789 : $urandom_range(1, 262143));
			n = 325;
			for (int i = 0; i < n; i++) begin
				send_pixel(rand_radiance(), rand_radiance(), rand_radiance());
				// let the pipeline run dry once, mid-way through phase 1
				if (i == 160 && phase == 1) begin
					rad_valid <= 1'b0;
					while (pending != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
